// File: hw/rtl/gsa_pkg.sv
package gsa_pkg;

  // Store geometry
  localparam int PLANES      = 4;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int PLANE_W     = 2;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int ADDR_W      = PLANE_W + ROW_W + COL_W;
  localparam int CELLS       = PLANES * MAX_ROWS * MAX_COLUMNS;

  // Configuration register indexes
  localparam logic [2:0] REG_TRUNC   = 3'd0;
  localparam logic [2:0] REG_CEILING = 3'd1;
  localparam logic [2:0] REG_ROWS    = 3'd2;
  localparam logic [2:0] REG_COLS    = 3'd3;
  localparam logic [2:0] REG_DEFAULT = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic prep1;
    logic prep2;
    logic dsq;
    logic test;
    logic div_step;
    logic base;
    logic sq;
    logic mul;
    logic write;
    logic advance;
    logic rd;
    logic fin;
  } gsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic plane_ok;
    logic touch;
    logic direct;
    logic win_last;
    logic div_last;
  } gsa_status_t;

endpackage

// File: hw/rtl/gsa_ctrl.sv
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  gsa_status_t status,
  output gsa_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_PREP1 = 4'd2;
  localparam logic [3:0] S_PREP2 = 4'd3;
  localparam logic [3:0] S_DIST  = 4'd4;
  localparam logic [3:0] S_TEST  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_BASE  = 4'd7;
  localparam logic [3:0] S_SQ    = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_WRITE = 4'd10;
  localparam logic [3:0] S_RD    = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] sq_cnt_r, sq_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    sq_cnt_nxt    = sq_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP1;
        end
      end
      S_PREP1: begin
        cmd.prep1 = 1'b1;
        if (status.is_read) state_nxt = S_RD;
        else if (!status.plane_ok) state_nxt = S_FIN;
        else state_nxt = S_PREP2;
      end
      S_PREP2: begin
        cmd.prep2 = 1'b1;
        state_nxt = S_DIST;
      end
      S_DIST: begin
        cmd.dsq   = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        cmd.test = 1'b1;
        if (!status.touch) begin
          if (status.win_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_DIST;
          end
        end else if (status.direct) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_BASE;
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        sq_cnt_nxt = 2'd0;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        sq_cnt_nxt = sq_cnt_r + 2'd1;
        if (sq_cnt_r == 2'd2) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (status.win_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_DIST;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sq_cnt_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A taken item always leaves idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("controller stayed idle after a transfer");

  // A new result only comes from the finish state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside finish");

  // Divider always hands over to the base step
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && status.div_last |=> state_r == S_BASE)
    else $error("divider exit lost");

  // No new item while the store is being cleared
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !cmd.load)
    else $error("item taken during clear");

endmodule

// File: hw/rtl/gsa_datapath.sv
module gsa_datapath
  import gsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  gsa_cmd_t           cmd,
  output gsa_status_t        status,
  input  logic               in_mode,
  input  logic [1:0]         in_plane,
  input  logic signed [11:0] in_center_x,
  input  logic signed [11:0] in_center_y,
  input  logic [7:0]         in_spread,
  input  logic [15:0]        in_weight,
  input  logic [7:0]         trunc,
  input  logic [15:0]        ceiling,
  input  logic [6:0]         rows,
  input  logic [6:0]         cols,
  input  logic [15:0]        dflt,
  output logic               out_was_read,
  output logic [15:0]        out_read_value
);

  // Item registers
  logic               mode_r;
  logic [1:0]         plane_r;
  logic signed [11:0] cx_r, cy_r;
  logic [7:0]         s_r;
  logic [15:0]        w_r;

  // Window and per-cell registers
  logic [15:0] ts_r, s2_r;
  logic [31:0] lim_r;
  logic [5:0]  minx_r, miny_r, xx_r, yy_r;
  logic [6:0]  maxx_r, maxy_r;
  logic [25:0] dx2_r, dy2_r;
  logic [16:0] add_r;
  logic [16:0] b_r;
  logic        inb_r;

  // Divider registers
  logic [16:0] rem_r;
  logic [15:0] num_r;
  logic [15:0] q_r;
  logic [3:0]  div_cnt_r;

  // Clear sweep and memory
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_q_r;

  logic              out_was_read_r;
  logic [15:0]       out_value_r;

  // Effective map size
  logic [6:0] rows_eff, cols_eff;
  always_comb begin
    rows_eff = (rows == 7'd0) ? 7'd1 : ((rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows);
    cols_eff = (cols == 7'd0) ? 7'd1 : ((cols > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : cols);
  end

  logic plane_ok;
  assign plane_ok = (int'(plane_r) < PLANES);

  // Window bounds: floor of edges, clamped to the map
  function automatic logic [5:0] win_lo(input logic signed [9:0] f, input logic [6:0] n);
    logic signed [10:0] fe;
    logic signed [10:0] top;
    fe  = {f[9], f};
    top = $signed({4'b0, n}) - 11'sd1;
    if (fe > top) fe = top;
    if (fe < 11'sd0) fe = 11'sd0;
    return fe[5:0];
  endfunction

  function automatic logic [6:0] win_hi(input logic signed [9:0] f, input logic [6:0] n,
                                        input logic [5:0] lo);
    logic signed [10:0] fe;
    logic signed [10:0] bot;
    fe  = {f[9], f};
    bot = $signed({5'b0, lo}) + 11'sd1;
    if (fe > $signed({4'b0, n})) fe = $signed({4'b0, n});
    if (fe < bot) fe = bot;
    return fe[6:0];
  endfunction

  logic signed [17:0] cx16, cy16, lox, hix, loy, hiy;
  logic [5:0]         minx_c, miny_c;
  always_comb begin
    cx16   = {{2{cx_r[11]}}, cx_r, 4'b0};
    cy16   = {{2{cy_r[11]}}, cy_r, 4'b0};
    lox    = cx16 - $signed({2'b0, ts_r});
    hix    = cx16 + $signed({2'b0, ts_r}) + 18'sd256;
    loy    = cy16 - $signed({2'b0, ts_r});
    hiy    = cy16 + $signed({2'b0, ts_r}) + 18'sd256;
    minx_c = win_lo(lox[17:8], cols_eff);
    miny_c = win_lo(loy[17:8], rows_eff);
  end

  // Offsets to the current cell
  logic signed [13:0] dx, dy;
  logic [12:0]        adx, ady;
  always_comb begin
    dx  = $signed({4'b0, xx_r, 4'b0}) - $signed({{2{cx_r[11]}}, cx_r});
    dy  = $signed({4'b0, yy_r, 4'b0}) - $signed({{2{cy_r[11]}}, cy_r});
    adx = dx[13] ? 13'(-dx) : dx[12:0];
    ady = dy[13] ? 13'(-dy) : dy[12:0];
  end

  // Cell test and divider load
  logic [24:0] d;
  logic        touch, exact, gz;
  logic [31:0] numer;
  always_comb begin
    d     = 25'(dx2_r) + 25'(dy2_r);
    touch = ({1'b0, d, 8'b0} <= {2'b0, lim_r});
    exact = (dx2_r < 26'd64) && (dy2_r < 26'd64);
    gz    = (s_r == 8'd0) || (d > {7'b0, s2_r, 2'b0});
    numer = {1'b0, d[17:0], 13'b0} + {16'b0, s2_r};
  end

  // Restoring divide step by 2*s^2
  logic [17:0] trial;
  logic        qbit;
  always_comb begin
    trial = {rem_r, num_r[15]} - {1'b0, s2_r, 1'b0};
    qbit  = ({rem_r, num_r[15]} >= {1'b0, s2_r, 1'b0});
  end

  logic [33:0] sq_prod;
  logic [32:0] w_prod;
  logic [16:0] sum;
  assign sq_prod = b_r * b_r + 34'd32768;
  assign w_prod  = w_r * b_r + 33'd32768;
  assign sum     = {1'b0, rd_q_r} + add_r;

  // Read item bounds and address
  logic signed [12:0] xe, ye, xp8, yp8, xlim, ylim;
  logic               inb_c;
  always_comb begin
    xe    = {cx_r[11], cx_r};
    ye    = {cy_r[11], cy_r};
    xp8   = xe + 13'sd8;
    yp8   = ye + 13'sd8;
    xlim  = $signed({2'b0, cols_eff, 4'b0}) - 13'sd9;
    ylim  = $signed({2'b0, rows_eff, 4'b0}) - 13'sd9;
    inb_c = plane_ok && (xe >= -13'sd7) && (ye >= -13'sd7) && (xe <= xlim) && (ye <= ylim);
  end

  // Memory port selection
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;
  always_comb begin
    mem_we = cmd.clear || cmd.write;
    waddr  = cmd.clear ? clr_cnt_r : {plane_r, yy_r, xx_r};
    wdata  = cmd.clear ? 16'd0 : ((sum > {1'b0, ceiling}) ? ceiling : sum[15:0]);
    mem_re = cmd.dsq || cmd.rd;
    raddr  = cmd.rd ? {plane_r, yp8[9:4], xp8[9:4]} : {plane_r, yy_r, xx_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rd_q_r <= mem[raddr];
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      plane_r <= in_plane;
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      s_r     <= in_spread;
      w_r     <= in_weight;
    end
    if (cmd.prep1) begin
      ts_r <= trunc * s_r;
      s2_r <= s_r * s_r;
    end
    if (cmd.prep2) begin
      lim_r  <= ts_r * ts_r;
      minx_r <= minx_c;
      miny_r <= miny_c;
      maxx_r <= win_hi(hix[17:8], cols_eff, minx_c);
      maxy_r <= win_hi(hiy[17:8], rows_eff, miny_c);
      xx_r   <= minx_c;
      yy_r   <= miny_c;
    end
    if (cmd.dsq) begin
      dx2_r <= adx * adx;
      dy2_r <= ady * ady;
    end
    if (cmd.test) begin
      add_r     <= exact ? {1'b0, w_r} : 17'd0;
      rem_r     <= {1'b0, numer[31:16]};
      num_r     <= numer[15:0];
      q_r       <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= qbit ? trial[16:0] : {rem_r[15:0], num_r[15]};
      num_r     <= {num_r[14:0], 1'b0};
      q_r       <= {q_r[14:0], qbit};
      div_cnt_r <= div_cnt_r + 4'd1;
    end
    if (cmd.base) b_r <= 17'h10000 - {1'b0, q_r};
    if (cmd.sq) b_r <= sq_prod[32:16];
    if (cmd.mul) add_r <= {1'b0, w_prod[31:16]};
    if (cmd.advance) begin
      if ({1'b0, yy_r} + 7'd1 == maxy_r) begin
        yy_r <= miny_r;
        xx_r <= xx_r + 6'd1;
      end else begin
        yy_r <= yy_r + 6'd1;
      end
    end
    if (cmd.rd) inb_r <= inb_c;
    if (cmd.fin) begin
      out_was_read_r <= mode_r;
      out_value_r    <= mode_r ? (inb_r ? rd_q_r : dflt) : 16'd0;
    end
  end

  // Status back to the controller
  always_comb begin
    status.clear_last = &clr_cnt_r;
    status.is_read    = mode_r;
    status.plane_ok   = plane_ok;
    status.touch      = touch;
    status.direct     = exact || gz;
    status.win_last   = ({1'b0, xx_r} + 7'd1 == maxx_r) && ({1'b0, yy_r} + 7'd1 == maxy_r);
    status.div_last   = (div_cnt_r == 4'd15);
  end

  assign out_was_read   = out_was_read_r;
  assign out_read_value = out_value_r;

endmodule

// File: hw/rtl/gaussian_splat_accumulate_top.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | mode, plane, center_x, center_y, spread, weight
// out     | output    | out_valid / out_ready | was_read, read_value
// cfg     | input     | psel/penable/pready   | paddr, pwdata, prdata (APB-style)
//
// After reset a clearing pass writes zero to all 16384 cells, one a cycle; no items meanwhile.
// Read item: load, prepare, read and finish states (one memory read port, registered data).
// Splat: load, prepare, per window cell distance and test (outside circle), plus write (exact or
// zero Gaussian) or 16-step divider, base, three squarings, weight multiply, write; then finish.
// One item at a time; a new item is taken while the previous result still waits on out.
// Reset is synchronous, active low; a stalled result holds its register and the finish state.
module gaussian_splat_accumulate_top
  import gsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [1:0]         in_plane,
  input  logic signed [11:0] in_center_x,
  input  logic signed [11:0] in_center_y,
  input  logic [7:0]         in_spread,
  input  logic [15:0]        in_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_was_read,
  output logic [15:0]        out_read_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]  trunc_r;
  logic [15:0] ceiling_r;
  logic [6:0]  rows_r;
  logic [6:0]  cols_r;
  logic [15:0] dflt_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_r   <= 8'd16;
      ceiling_r <= 16'd256;
      rows_r    <= 7'd64;
      cols_r    <= 7'd64;
      dflt_r    <= 16'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TRUNC:   trunc_r   <= pwdata[7:0];
        REG_CEILING: ceiling_r <= pwdata[15:0];
        REG_ROWS:    rows_r    <= pwdata[6:0];
        REG_COLS:    cols_r    <= pwdata[6:0];
        REG_DEFAULT: dflt_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_TRUNC:   prdata = {24'd0, trunc_r};
      REG_CEILING: prdata = {16'd0, ceiling_r};
      REG_ROWS:    prdata = {25'd0, rows_r};
      REG_COLS:    prdata = {25'd0, cols_r};
      REG_DEFAULT: prdata = {16'd0, dflt_r};
      default:     prdata = 32'd0;
    endcase
  end

  gsa_cmd_t    cmd;
  gsa_status_t status;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gsa_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_mode        (in_mode),
    .in_plane       (in_plane),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_spread      (in_spread),
    .in_weight      (in_weight),
    .trunc          (trunc_r),
    .ceiling        (ceiling_r),
    .rows           (rows_r),
    .cols           (cols_r),
    .dflt           (dflt_r),
    .out_was_read   (out_was_read),
    .out_read_value (out_read_value)
  );

endmodule

// File: bench/tb.sv
`default_nettype none

module tb;
  import gsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Heatmap predictor and result scoreboard
  class heat_scoreboard;
    typedef struct {
      bit          was_read;
      logic [15:0] value;
    } answer_t;

    logic [15:0] heat[CELLS];
    int unsigned trunc_q, ceil_q, rows_q, cols_q, dflt_q;
    answer_t     answers[$];
    int          errors;
    int          splats, reads;

    function new();
      foreach (heat[i]) heat[i] = '0;
      trunc_q = 16; ceil_q = 256; rows_q = 64; cols_q = 64; dflt_q = 0;
      errors = 0; splats = 0; reads = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_TRUNC:   trunc_q = val[7:0];
        REG_CEILING: ceil_q = val[15:0];
        REG_ROWS:    rows_q = val[6:0];
        REG_COLS:    cols_q = val[6:0];
        REG_DEFAULT: dflt_q = val[15:0];
        default: ;
      endcase
    endfunction

    function longint eff(int unsigned v, longint max_v);
      if (v < 1) return 1;
      if (v > max_v) return max_v;
      return v;
    endfunction

    function longint clip(longint a, longint lo, longint hi);
      if (a > hi) a = hi;
      if (a < lo) a = lo;
      return a;
    endfunction

    // (1 - a/8)^8 style falloff in Q1.16
    function longint unsigned falloff(longint unsigned d, longint unsigned s);
      longint unsigned s2, q, b;
      s2 = s * s;
      if (s == 0 || d > 4 * s2) return 0;
      q = (d * 8192 + s2) / (2 * s2);
      b = 65536 - q;
      repeat (3) b = (b * b + 32768) >> 16;
      return b;
    endfunction

    function void add_splat(int pl, longint cx, longint cy, longint unsigned s,
                            longint unsigned w);
      longint rows, cols, ts, x0, x1, y0, y1, dx, dy;
      longint unsigned lim, d, add, sum;
      int idx;
      rows = eff(rows_q, MAX_ROWS);
      cols = eff(cols_q, MAX_COLUMNS);
      ts = longint'(trunc_q) * longint'(s);
      lim = ts * ts;
      if (pl >= PLANES) return;
      x0 = clip((cx * 16 - ts) >>> 8, 0, cols - 1);
      x1 = clip((cx * 16 + ts + 256) >>> 8, x0 + 1, cols);
      y0 = clip((cy * 16 - ts) >>> 8, 0, rows - 1);
      y1 = clip((cy * 16 + ts + 256) >>> 8, y0 + 1, rows);
      for (longint xx = x0; xx < x1; xx++) begin
        for (longint yy = y0; yy < y1; yy++) begin
          dx = xx * 16 - cx;
          dy = yy * 16 - cy;
          d = dx * dx + dy * dy;
          if (d * 256 > lim) continue;
          if (dx * dx < 64 && dy * dy < 64) add = w;
          else add = (w * falloff(d, s) + 32768) >> 16;
          idx = int'((pl * MAX_ROWS + yy) * MAX_COLUMNS + xx);
          sum = heat[idx] + add;
          if (sum > ceil_q) sum = ceil_q;
          heat[idx] = sum[15:0];
        end
      end
    endfunction

    function logic [15:0] cell_at(int pl, longint x, longint y);
      longint rows, cols;
      rows = eff(rows_q, MAX_ROWS);
      cols = eff(cols_q, MAX_COLUMNS);
      if (pl >= PLANES) return 16'(dflt_q);
      if (x < -7 || y < -7 || x > cols * 16 - 9 || y > rows * 16 - 9) return 16'(dflt_q);
      return heat[int'((pl * MAX_ROWS + (y + 8) / 16) * MAX_COLUMNS + (x + 8) / 16)];
    endfunction

    // Accepted input transfer: update the store, queue the answer
    function void note_item(bit mode, logic [1:0] pl, logic signed [11:0] cx,
                            logic signed [11:0] cy, logic [7:0] s, logic [15:0] w);
      answer_t a;
      if (!mode) begin
        add_splat(pl, cx, cy, s, w);
        a.was_read = 0; a.value = '0;
        splats++;
      end else begin
        a.was_read = 1; a.value = cell_at(pl, cx, cy);
        reads++;
      end
      answers.push_back(a);
    endfunction

    function void check_result(bit was_read, logic [15:0] value);
      answer_t a;
      if (answers.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      a = answers.pop_front();
      if (was_read !== a.was_read) begin
        $error("was_read: expected %0d, got %0d", a.was_read, was_read);
        errors++;
      end
      if (value !== a.value) begin
        $error("read_value: expected %h, got %h", a.value, value);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic [1:0]         in_plane;
  logic signed [11:0] in_center_x;
  logic signed [11:0] in_center_y;
  logic [7:0]         in_spread;
  logic [15:0]        in_weight;
  logic               out_valid;
  logic               out_ready;
  logic               out_was_read;
  logic [15:0]        out_read_value;
  logic               psel, penable, pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               pready;

  heat_scoreboard sb;
  bit             busy_phase;

  gaussian_splat_accumulate_top u_top (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("simulation failed");
    $finish;
  end

  function int draw_gap();
    return busy_phase ? 0 : $urandom_range(0, 13);
  endfunction

  // Register write with a setup phase and an access phase
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic load_regs(int t, int c, int r, int co, int d);
    write_reg(REG_TRUNC, t);
    write_reg(REG_CEILING, c);
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, co);
    write_reg(REG_DEFAULT, d);
  endtask

  task automatic send_item(bit mode, logic [1:0] pl, logic signed [11:0] cx,
                           logic signed [11:0] cy, logic [7:0] s, logic [15:0] w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_mode = mode; in_plane = pl; in_center_x = cx; in_center_y = cy;
    in_spread = s; in_weight = w; in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(mode, pl, cx, cy, s, w);
    @(negedge clk);
  endtask

  // Drain the result channel, then let the block settle
  task automatic drain();
    in_valid = 0;
    while (sb.answers.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Random item aimed mostly at the live part of the map
  task automatic random_item();
    int rows, cols;
    logic signed [11:0] cx, cy;
    logic [7:0] s;
    rows = int'(sb.eff(sb.rows_q, MAX_ROWS));
    cols = int'(sb.eff(sb.cols_q, MAX_COLUMNS));
    if ($urandom_range(0, 9) == 0) begin
      cx = 12'($urandom); cy = 12'($urandom);
    end else begin
      cx = 12'(int'($urandom_range(0, cols * 16 + 32)) - 16);
      cy = 12'(int'($urandom_range(0, rows * 16 + 32)) - 16);
    end
    s = 8'(($urandom_range(0, 19) == 0) ? $urandom_range(128, 255) : $urandom_range(1, 40));
    send_item(1'($urandom_range(0, 1)), 2'($urandom), cx, cy, s, 16'($urandom));
  endtask

  // Result side with random stalls
  initial begin
    int stall;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = draw_gap();
      if (stall > 0) begin
        out_ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_was_read, out_read_value);
    end
  end

  initial begin
    sb = new();
    busy_phase = 0;
    rst_n = 0; in_valid = 0; in_mode = 0; in_plane = 0; in_center_x = 0;
    in_center_y = 0; in_spread = 0; in_weight = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;

    // Reset values, directed corners
    load_regs(16, 256, 64, 64, 0);
    send_item(1, 0, 0, 0, 1, 0);
    send_item(0, 0, 80, 80, 16, 16'h0100);
    send_item(1, 0, 80, 80, 0, 0);
    send_item(1, 0, 72, 80, 0, 0);
    send_item(1, 0, 71, 80, 0, 0);
    send_item(0, 1, 83, 85, 32, 16'hFFFF);
    send_item(1, 1, 83, 85, 0, 0);
    send_item(1, 1, 96, 85, 0, 0);
    send_item(0, 2, 160, 160, 0, 16'h0080);
    send_item(0, 2, 163, 160, 0, 16'h0080);
    send_item(1, 2, 160, 160, 0, 0);
    send_item(0, 3, 320, 320, 48, 16'h0000);
    send_item(0, 3, -12'sd2048, -12'sd2048, 255, 16'h00FF);
    send_item(0, 3, 12'sd2047, 12'sd2047, 255, 16'h00FF);
    send_item(1, 3, -7, -7, 0, 0);
    send_item(1, 3, -8, 0, 0, 0);
    send_item(1, 3, 64 * 16 - 9, 64 * 16 - 9, 0, 0);
    send_item(1, 3, 64 * 16 - 8, 0, 0, 0);
    send_item(1, 0, -12'sd2048, 12'sd2047, 8'hFF, 16'hFFFF);
    drain();

    // Widest truncation, full-range ceiling and default
    load_regs(255, 65535, 64, 64, 65535);
    send_item(0, 1, 512, 512, 255, 16'h0101);
    send_item(0, 1, 500, 40, 1, 16'hFFFF);
    send_item(1, 1, 512, 512, 0, 0);
    send_item(1, 1, 500, 40, 0, 0);
    send_item(1, 1, 12'sd2047, 0, 0, 0);
    drain();

    // Degenerate sizes and zero ceiling
    load_regs(0, 0, 0, 127, 16'h1234);
    send_item(0, 0, 0, 0, 20, 16'h4000);
    send_item(0, 0, 40, 0, 20, 16'h4000);
    send_item(1, 0, 0, 0, 0, 0);
    send_item(1, 0, 0, 9, 0, 0);
    send_item(1, 0, 1000, 0, 0, 0);
    drain();

    // Random phases
    for (int ph = 0; ph < 8; ph++) begin
      busy_phase = (ph % 3 == 2);
      load_regs($urandom_range(4, 24), $urandom, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 64),
                $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 64), $urandom);
      repeat (50) random_item();
      drain();
    end

    $display("covered %0d splats and %0d reads over 11 register settings",
             sb.splats, sb.reads);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_ctrl.sv
hw/rtl/gsa_datapath.sv
hw/rtl/gaussian_splat_accumulate_top.sv
bench/tb.sv
